// ----- rtl/complex_arith_unit_top_defines.svh -----
// Assertion macros used by the complex arithmetic unit top level.
`ifndef COMPLEX_ARITH_UNIT_TOP_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CAU_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CAU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cau_pkg.sv -----
// Shared opcodes, defaults and sideband type for the complex arithmetic unit.
package cau_pkg;

   localparam int OP_W = 3;

   localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL   = 3'd2;
   localparam logic [OP_W-1:0] OP_SCALE = 3'd3;
   localparam logic [OP_W-1:0] OP_DIV   = 3'd4;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 8;

   // control bits that ride along with an item through the divider stages
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            neg_re;
      logic            neg_im;
      logic            dz;
   } side_type;

endpackage

// ----- rtl/cau_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, for both result parts.
module cau_divider #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_stall,
   input  cau_pkg::side_type        in_side,
   input  logic [2*DATA_WIDTH-1:0]  in_mag_re,
   input  logic [2*DATA_WIDTH-1:0]  in_mag_im,
   input  logic [2*DATA_WIDTH-1:0]  in_den,
   input  logic [DATA_WIDTH-1:0]    in_quo_re,
   input  logic [DATA_WIDTH-1:0]    in_quo_im,
   input  logic                     in_ovf_re,
   input  logic                     in_ovf_im,
   output logic                     out_valid,
   input  logic                     out_stall,
   output cau_pkg::side_type        out_side,
   output logic [DATA_WIDTH-1:0]    out_quo_re,
   output logic [DATA_WIDTH-1:0]    out_quo_im,
   output logic                     out_ovf_re,
   output logic                     out_ovf_im
);

   localparam int WM = 2 * DATA_WIDTH;
   localparam int WR = WM + DATA_WIDTH + FRAC_BITS;
   localparam int NS = DATA_WIDTH + 1;

   logic [NS-1:0]          en;
   logic [NS-1:0]          v_ff;
   logic [NS-1:0]          v_in;
   cau_pkg::side_type      side_ff [NS];
   cau_pkg::side_type      side_in [NS];
   logic [WM-1:0]          den_ff [NS];
   logic [WM-1:0]          den_in [NS];
   logic [WR-1:0]          rem_re_ff [NS];
   logic [WR-1:0]          rem_re_in [NS];
   logic [WR-1:0]          rem_im_ff [NS];
   logic [WR-1:0]          rem_im_in [NS];
   logic [DATA_WIDTH-1:0]  quo_re_ff [NS];
   logic [DATA_WIDTH-1:0]  quo_re_in [NS];
   logic [DATA_WIDTH-1:0]  quo_im_ff [NS];
   logic [DATA_WIDTH-1:0]  quo_im_in [NS];
   logic [NS-1:0]          ovf_re_ff;
   logic [NS-1:0]          ovf_re_in;
   logic [NS-1:0]          ovf_im_ff;
   logic [NS-1:0]          ovf_im_in;

   logic [WR-1:0] head_num_re;
   logic [WR-1:0] head_num_im;
   logic [WR-1:0] head_lim;
   logic          head_div;

   // a stage loads when it is empty or its item moves on
   assign en[NS-1] = !v_ff[NS-1] || !out_stall;
   for (genvar k = 0; k < NS - 1; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end
   assign in_stall = !en[0];

   // head stage: scale numerators, flag quotients that reach 2^DATA_WIDTH
   assign head_div    = (in_side.op == cau_pkg::OP_DIV);
   assign head_num_re = WR'(in_mag_re) << FRAC_BITS;
   assign head_num_im = WR'(in_mag_im) << FRAC_BITS;
   assign head_lim    = WR'(in_den) << DATA_WIDTH;

   assign v_in[0]      = in_valid;
   assign side_in[0]   = in_side;
   assign den_in[0]    = in_den;
   assign rem_re_in[0] = head_num_re;
   assign rem_im_in[0] = head_num_im;
   assign quo_re_in[0] = head_div ? '0 : in_quo_re;
   assign quo_im_in[0] = head_div ? '0 : in_quo_im;
   assign ovf_re_in[0] = head_div ? (head_num_re >= head_lim) : in_ovf_re;
   assign ovf_im_in[0] = head_div ? (head_num_im >= head_lim) : in_ovf_im;

   for (genvar k = 1; k < NS; k++) begin : g_bit
      localparam int B = DATA_WIDTH - k;
      logic [WR-1:0] trial;
      logic          is_div;
      logic          take_re;
      logic          take_im;

      assign is_div  = (side_ff[k-1].op == cau_pkg::OP_DIV);
      assign trial   = WR'(den_ff[k-1]) << B;
      assign take_re = is_div && (rem_re_ff[k-1] >= trial);
      assign take_im = is_div && (rem_im_ff[k-1] >= trial);

      assign v_in[k]      = v_ff[k-1];
      assign side_in[k]   = side_ff[k-1];
      assign den_in[k]    = den_ff[k-1];
      assign rem_re_in[k] = take_re ? (rem_re_ff[k-1] - trial) : rem_re_ff[k-1];
      assign rem_im_in[k] = take_im ? (rem_im_ff[k-1] - trial) : rem_im_ff[k-1];
      assign quo_re_in[k] = quo_re_ff[k-1] | (DATA_WIDTH'(take_re) << B);
      assign quo_im_in[k] = quo_im_ff[k-1] | (DATA_WIDTH'(take_im) << B);
      assign ovf_re_in[k] = ovf_re_ff[k-1];
      assign ovf_im_in[k] = ovf_im_ff[k-1];
   end

   for (genvar k = 0; k < NS; k++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= v_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            side_ff[k]   <= side_in[k];
            den_ff[k]    <= den_in[k];
            rem_re_ff[k] <= rem_re_in[k];
            rem_im_ff[k] <= rem_im_in[k];
            quo_re_ff[k] <= quo_re_in[k];
            quo_im_ff[k] <= quo_im_in[k];
            ovf_re_ff[k] <= ovf_re_in[k];
            ovf_im_ff[k] <= ovf_im_in[k];
         end
      end
   end

   assign out_valid  = v_ff[NS-1];
   assign out_side   = side_ff[NS-1];
   assign out_quo_re = quo_re_ff[NS-1];
   assign out_quo_im = quo_im_ff[NS-1];
   assign out_ovf_re = ovf_re_ff[NS-1];
   assign out_ovf_im = ovf_im_ff[NS-1];

endmodule

// ----- rtl/complex_arith_unit_top.sv -----
// Top level of the pipelined fixed-point complex arithmetic unit.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_op, req_a_re, req_a_im, req_b_re, req_b_im
//   rsp      out        rsp_valid/rsp_stall   rsp_res_re, rsp_res_im, rsp_saturated,
//                                             rsp_divide_by_zero
//
// One item per cycle sustained while rsp_stall stays low; the divider resolves one
// quotient bit per stage.
// Every operation runs through the same stages, so results leave in order.
// Reset clears only the stage valid bits.
// Each stage loads whenever it is empty or its item moves on, so bubbles close up
// under an rsp stall; req_stall rises only once every stage holds an item.
`include "complex_arith_unit_top_defines.svh"

module complex_arith_unit_top #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cau_pkg::OP_W-1:0]      req_op,
   input  logic signed [DATA_WIDTH-1:0]  req_a_re,
   input  logic signed [DATA_WIDTH-1:0]  req_a_im,
   input  logic signed [DATA_WIDTH-1:0]  req_b_re,
   input  logic signed [DATA_WIDTH-1:0]  req_b_im,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [DATA_WIDTH-1:0]  rsp_res_re,
   output logic signed [DATA_WIDTH-1:0]  rsp_res_im,
   output logic                          rsp_saturated,
   output logic                          rsp_divide_by_zero
);

   localparam int WP = 2 * DATA_WIDTH;
   localparam int WS = WP + 1;
   localparam int WM = WP;
   localparam logic [DATA_WIDTH-1:0] POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] NEG_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // magnitude and overflow to {sat, value} for one result part
   function automatic logic [DATA_WIDTH:0] clip_part(input logic [DATA_WIDTH-1:0] mag,
                                                     input logic ovf,
                                                     input logic neg);
      logic                  over;
      logic [DATA_WIDTH-1:0] val;
      if (neg) begin
         over = ovf || (mag[DATA_WIDTH-1] && (|mag[DATA_WIDTH-2:0]));
         val  = over ? NEG_MIN : (~mag + 1'b1);
      end else begin
         over = ovf || mag[DATA_WIDTH-1];
         val  = over ? POS_MAX : mag;
      end
      return {over, val};
   endfunction

   logic en1, en2, en3, en4, out_en;

   // stage 1: operand capture
   logic                          s1_v_ff;
   logic [cau_pkg::OP_W-1:0]      s1_op_ff;
   logic signed [DATA_WIDTH-1:0]  s1_a_re_ff, s1_a_im_ff, s1_b_re_ff, s1_b_im_ff;

   // stage 2: products and plain sums or differences
   logic                          s2_v_ff;
   logic [cau_pkg::OP_W-1:0]      s2_op_ff;
   logic signed [WP-1:0]          s2_rr_ff, s2_ii_ff, s2_ir_ff, s2_ri_ff;
   logic signed [WP-1:0]          s2_rr_in, s2_ii_in, s2_ir_in, s2_ri_in;
   logic [WP-1:0]                 s2_sqr_ff, s2_sqi_ff;
   logic [WP-1:0]                 s2_sqr_in, s2_sqi_in;
   logic signed [DATA_WIDTH:0]    s2_as_re_ff, s2_as_im_ff;
   logic signed [DATA_WIDTH:0]    s2_as_re_in, s2_as_im_in;

   // stage 3: exact signed results before scaling, and divisor
   logic                          s3_v_ff;
   logic [cau_pkg::OP_W-1:0]      s3_op_ff;
   logic signed [WS-1:0]          s3_re_ff, s3_im_ff;
   logic signed [WS-1:0]          s3_re_in, s3_im_in;
   logic [WM-1:0]                 s3_den_ff;
   logic [WM-1:0]                 s3_den_in;

   // stage 4: sign and magnitude
   logic                          s4_v_ff;
   cau_pkg::side_type             s4_side_ff, s4_side_in;
   logic [WM-1:0]                 s4_mag_re_ff, s4_mag_im_ff, s4_den_ff;
   logic [DATA_WIDTH-1:0]         s4_quo_re_ff, s4_quo_im_ff;
   logic                          s4_ovf_re_ff, s4_ovf_im_ff;
   logic signed [WS-1:0]          abs_re, abs_im;
   logic [WM-1:0]                 mag_re, mag_im, sh_re, sh_im;

   // divider outputs
   logic                          dv_in_stall;
   logic                          dv_valid;
   cau_pkg::side_type             dv_side;
   logic [DATA_WIDTH-1:0]         dv_quo_re, dv_quo_im;
   logic                          dv_ovf_re, dv_ovf_im;

   // result register
   logic                          rsp_valid_ff;
   logic [DATA_WIDTH-1:0]         res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic                          sat_ff, sat_in, dz_ff, dz_in;
   logic [DATA_WIDTH:0]           clip_re, clip_im;
   logic                          op_ok;

   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign en4       = !s4_v_ff || !dv_in_stall;
   assign en3       = !s3_v_ff || en4;
   assign en2       = !s2_v_ff || en3;
   assign en1       = !s1_v_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_v_ff <= req_valid;
         if (en2) s2_v_ff <= s1_v_ff;
         if (en3) s3_v_ff <= s2_v_ff;
         if (en4) s4_v_ff <= s3_v_ff;
         if (out_en) rsp_valid_ff <= dv_valid;
      end
   end

   // ---- stage 1
   always_ff @(posedge clock) begin
      if (en1) begin
         s1_op_ff   <= req_op;
         s1_a_re_ff <= req_a_re;
         s1_a_im_ff <= req_a_im;
         s1_b_re_ff <= req_b_re;
         s1_b_im_ff <= req_b_im;
      end
   end

   // ---- stage 2
   assign s2_rr_in  = s1_a_re_ff * s1_b_re_ff;
   assign s2_ii_in  = s1_a_im_ff * s1_b_im_ff;
   assign s2_ir_in  = s1_a_im_ff * s1_b_re_ff;
   assign s2_ri_in  = s1_a_re_ff * s1_b_im_ff;
   assign s2_sqr_in = s1_b_re_ff * s1_b_re_ff;
   assign s2_sqi_in = s1_b_im_ff * s1_b_im_ff;

   always_comb begin
      if (s1_op_ff == cau_pkg::OP_SUB) begin
         s2_as_re_in = (DATA_WIDTH+1)'(s1_a_re_ff) - (DATA_WIDTH+1)'(s1_b_re_ff);
         s2_as_im_in = (DATA_WIDTH+1)'(s1_a_im_ff) - (DATA_WIDTH+1)'(s1_b_im_ff);
      end else begin
         s2_as_re_in = (DATA_WIDTH+1)'(s1_a_re_ff) + (DATA_WIDTH+1)'(s1_b_re_ff);
         s2_as_im_in = (DATA_WIDTH+1)'(s1_a_im_ff) + (DATA_WIDTH+1)'(s1_b_im_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_op_ff    <= s1_op_ff;
         s2_rr_ff    <= s2_rr_in;
         s2_ii_ff    <= s2_ii_in;
         s2_ir_ff    <= s2_ir_in;
         s2_ri_ff    <= s2_ri_in;
         s2_sqr_ff   <= s2_sqr_in;
         s2_sqi_ff   <= s2_sqi_in;
         s2_as_re_ff <= s2_as_re_in;
         s2_as_im_ff <= s2_as_im_in;
      end
   end

   // ---- stage 3
   always_comb begin
      case (s2_op_ff)
         cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
            s3_re_in = WS'(s2_as_re_ff);
            s3_im_in = WS'(s2_as_im_ff);
         end
         cau_pkg::OP_MUL: begin
            s3_re_in = WS'(s2_rr_ff) - WS'(s2_ii_ff);
            s3_im_in = WS'(s2_ir_ff) + WS'(s2_ri_ff);
         end
         cau_pkg::OP_SCALE: begin
            s3_re_in = WS'(s2_rr_ff);
            s3_im_in = WS'(s2_ir_ff);
         end
         cau_pkg::OP_DIV: begin
            // a * conj(b), divided by |b|^2 later
            s3_re_in = WS'(s2_rr_ff) + WS'(s2_ii_ff);
            s3_im_in = WS'(s2_ir_ff) - WS'(s2_ri_ff);
         end
         default: begin
            s3_re_in = '0;
            s3_im_in = '0;
         end
      endcase
   end

   assign s3_den_in = WM'(s2_sqr_ff) + WM'(s2_sqi_ff);

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_op_ff  <= s2_op_ff;
         s3_re_ff  <= s3_re_in;
         s3_im_ff  <= s3_im_in;
         s3_den_ff <= s3_den_in;
      end
   end

   // ---- stage 4
   assign abs_re = s3_re_ff[WS-1] ? -s3_re_ff : s3_re_ff;
   assign abs_im = s3_im_ff[WS-1] ? -s3_im_ff : s3_im_ff;
   assign mag_re = abs_re[WM-1:0];
   assign mag_im = abs_im[WM-1:0];

   // truncation toward zero: shift the magnitude, not the signed value
   always_comb begin
      if (s3_op_ff inside {cau_pkg::OP_MUL, cau_pkg::OP_SCALE}) begin
         sh_re = mag_re >> FRAC_BITS;
         sh_im = mag_im >> FRAC_BITS;
      end else begin
         sh_re = mag_re;
         sh_im = mag_im;
      end
   end

   always_comb begin
      s4_side_in.op     = s3_op_ff;
      s4_side_in.neg_re = s3_re_ff[WS-1];
      s4_side_in.neg_im = s3_im_ff[WS-1];
      s4_side_in.dz     = (s3_op_ff == cau_pkg::OP_DIV) && (s3_den_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_side_ff   <= s4_side_in;
         s4_mag_re_ff <= mag_re;
         s4_mag_im_ff <= mag_im;
         s4_den_ff    <= s3_den_ff;
         s4_quo_re_ff <= sh_re[DATA_WIDTH-1:0];
         s4_quo_im_ff <= sh_im[DATA_WIDTH-1:0];
         s4_ovf_re_ff <= |sh_re[WM-1:DATA_WIDTH];
         s4_ovf_im_ff <= |sh_im[WM-1:DATA_WIDTH];
      end
   end

   // ---- divider stages (non-divide items pass through untouched)
   cau_divider #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s4_v_ff),
      .in_stall   (dv_in_stall),
      .in_side    (s4_side_ff),
      .in_mag_re  (s4_mag_re_ff),
      .in_mag_im  (s4_mag_im_ff),
      .in_den     (s4_den_ff),
      .in_quo_re  (s4_quo_re_ff),
      .in_quo_im  (s4_quo_im_ff),
      .in_ovf_re  (s4_ovf_re_ff),
      .in_ovf_im  (s4_ovf_im_ff),
      .out_valid  (dv_valid),
      .out_stall  (!out_en),
      .out_side   (dv_side),
      .out_quo_re (dv_quo_re),
      .out_quo_im (dv_quo_im),
      .out_ovf_re (dv_ovf_re),
      .out_ovf_im (dv_ovf_im)
   );

   // ---- saturation and result register
   assign clip_re = clip_part(dv_quo_re, dv_ovf_re, dv_side.neg_re);
   assign clip_im = clip_part(dv_quo_im, dv_ovf_im, dv_side.neg_im);
   assign op_ok   = dv_side.op inside {cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL,
                                       cau_pkg::OP_SCALE, cau_pkg::OP_DIV};

   always_comb begin
      res_re_in = '0;
      res_im_in = '0;
      sat_in    = 1'b0;
      dz_in     = 1'b0;
      if (dv_side.dz) begin
         dz_in = 1'b1;
      end else if (op_ok) begin
         res_re_in = clip_re[DATA_WIDTH-1:0];
         res_im_in = clip_im[DATA_WIDTH-1:0];
         sat_in    = clip_re[DATA_WIDTH] || clip_im[DATA_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         sat_ff    <= sat_in;
         dz_ff     <= dz_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_res_re         = res_re_ff;
   assign rsp_res_im         = res_im_ff;
   assign rsp_saturated      = sat_ff;
   assign rsp_divide_by_zero = dz_ff;

   `CAU_ASSERT_IMPLIES(a_dz_clean, clock, reset, rsp_valid && rsp_divide_by_zero, rsp_res_re == '0 && rsp_res_im == '0 && !rsp_saturated, "zero divisor item carries a nonzero result or saturation")
   `CAU_ASSERT_IMPLIES(a_sat_at_limit, clock, reset, rsp_valid && rsp_saturated, res_re_ff == POS_MAX || res_re_ff == NEG_MIN || res_im_ff == POS_MAX || res_im_ff == NEG_MIN, "saturated item has no part at a range limit")
   `CAU_ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && !req_stall, s1_v_ff, "accepted item missing from the first stage")

endmodule
